// File: hw/rtl/bfsc_pkg.sv
// Shared types and constants for the byte four-square cipher.
// No dependencies.
package bfsc_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = 8;

  localparam logic [31:0] LcgMul  = 32'd1103515245;
  localparam logic [31:0] LcgAdd  = 32'd12345;
  localparam logic [31:0] LcgMask = 32'h7FFF_FFFF;
  localparam logic [31:0] HashMul = 32'd31;
  localparam logic [7:0]  PadByte = 8'h20;

  typedef enum logic [1:0] {
    CmdKeyChar = 2'd0,
    CmdCommit  = 2'd1,
    CmdEncrypt = 2'd2,
    CmdDecrypt = 2'd3
  } cmd_e;

  // Control from the sequencer to the table store.
  typedef struct packed {
    logic             wr_en;
    logic             sel;      // 0 upper right, 1 lower left
    logic             inv;      // 1 selects the inverse table
    logic [AddrW-1:0] wr_addr;
    logic [7:0]       wr_data;
  } tbl_wr_t;

endpackage

// File: hw/rtl/bfsc_mod.sv
// Multi-cycle remainder unit: a 31-bit value modulo an 9-bit divisor.
// Uses bfsc_pkg; one quotient bit per cycle, restoring division.
module bfsc_mod
  import bfsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] dividend_i,
  input  logic [8:0]  divisor_i,
  output logic        done_o,
  output logic [7:0]  rem_o
);

  logic [30:0] num_q, num_d;
  logic [9:0]  rem_q, rem_d;
  logic [8:0]  div_q, div_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [9:0]  shifted;

  // One restoring step per cycle, most significant bit first.
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[8:0], num_q[30]};
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 5'd30;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[29:0], 1'b0};
      if (shifted >= {1'b0, div_q}) begin
        rem_d = shifted - {1'b0, div_q};
      end else begin
        rem_d = shifted;
      end
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[7:0];

endmodule

// File: hw/rtl/bfsc_store.sv
// Table store: four 256 x 8 synchronous memories (forward and inverse tables
// of both keyed squares). Uses bfsc_pkg; reads are registered.
module bfsc_store
  import bfsc_pkg::*;
(
  input  logic             clk_i,
  input  tbl_wr_t          wr_i,
  input  logic [AddrW-1:0] ur_addr_i,
  input  logic [AddrW-1:0] ll_addr_i,
  input  logic [AddrW-1:0] uri_addr_i,
  input  logic [AddrW-1:0] lli_addr_i,
  output logic [7:0]       ur_data_o,
  output logic [7:0]       ll_data_o,
  output logic [7:0]       uri_data_o,
  output logic [7:0]       lli_data_o
);

  logic [7:0] ur_mem  [TableDepth];
  logic [7:0] ll_mem  [TableDepth];
  logic [7:0] uri_mem [TableDepth];
  logic [7:0] lli_mem [TableDepth];

  // One write port per memory, selected by the sequencer.
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      unique case ({wr_i.sel, wr_i.inv})
        2'b00:   ur_mem[wr_i.wr_addr]  <= wr_i.wr_data;
        2'b01:   uri_mem[wr_i.wr_addr] <= wr_i.wr_data;
        2'b10:   ll_mem[wr_i.wr_addr]  <= wr_i.wr_data;
        default: lli_mem[wr_i.wr_addr] <= wr_i.wr_data;
      endcase
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    ur_data_o  <= ur_mem[ur_addr_i];
    ll_data_o  <= ll_mem[ll_addr_i];
    uri_data_o <= uri_mem[uri_addr_i];
    lli_data_o <= lli_mem[lli_addr_i];
  end

endmodule

// File: hw/rtl/byte_four_square_cipher_top.sv
// Byte four-square cipher over 256 byte values. The keyed squares live in
// four 256 x 8 synchronous memories. After reset a clearing pass writes the
// identity into all four tables, one entry of one table per cycle; no item is
// accepted then. A keyword character only updates the keyword hash. An
// encrypt or decrypt pair issues its memory read in the accept cycle, and the
// lookup cycle loads the output register from the registered read data. A
// result waiting in the output register does not block the input; a following
// pair waits in the lookup cycle until the result is taken. A commit runs an
// identity fill, then, for a nonempty keyword, 255 shuffle steps, each bound
// by the bit-serial remainder unit plus the LCG step and a read-modify-write
// swap, and an inverse rebuild that reads each entry in one state and writes
// it in the next.
// Uses bfsc_pkg, bfsc_mod, bfsc_store.
module byte_four_square_cipher_top
  import bfsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic        key_select_i,
  input  logic [15:0] key_char_i,
  input  logic [7:0]  first_byte_i,
  input  logic [7:0]  second_byte_i,
  input  logic        second_valid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_first_o,
  output logic [7:0]  out_second_o
);

  typedef enum logic [10:0] {
    StClear = 11'b00000000001,
    StIdle  = 11'b00000000010,
    StLook  = 11'b00000000100,
    StFill  = 11'b00000001000,
    StLcg   = 11'b00000010000,
    StMod   = 11'b00000100000,
    StRdI   = 11'b00001000000,
    StRdJ   = 11'b00010000000,
    StSwap  = 11'b00100000000,
    StInvRd = 11'b01000000000,
    StInvWr = 11'b10000000000
  } state_e;

  state_e      state_q, state_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [31:0] hash_q, hash_d;
  logic        nonempty_q, nonempty_d;
  logic        sel_q, sel_d;
  logic        cmd_dec_q, cmd_dec_d;
  logic [31:0] seed_q, seed_d;
  logic [31:0] lcg_prod_q;
  logic [7:0]  j_q, j_d;
  logic [7:0]  vi_q, vi_d;
  logic [7:0]  a_q, a_d, b_q, b_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_first_q, out_first_d, out_second_q, out_second_d;
  logic        mod_first_q;
  logic        start_q;
  logic [31:0] seed_next;
  logic        mod_done;
  logic [7:0]  mod_rem;
  tbl_wr_t     wr;
  logic [7:0]  ur_addr, ll_addr, uri_addr, lli_addr;
  logic [7:0]  ur_data, ll_data, uri_data, lli_data;
  logic [7:0]  rd_fwd;
  logic [7:0]  b_eff;
  logic        accept;
  logic [7:0]  p, q;

  assign b_eff  = second_valid_i ? second_byte_i : PadByte;
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  // Read data of the table being built.
  assign rd_fwd = sel_q ? ll_data : ur_data;
  assign p = uri_data;
  assign q = lli_data;

  bfsc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (seed_q[30:0]),
    .divisor_i  (cnt_q + 9'd1),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  bfsc_store u_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .ur_addr_i  (ur_addr),
    .ll_addr_i  (ll_addr),
    .uri_addr_i (uri_addr),
    .lli_addr_i (lli_addr),
    .ur_data_o  (ur_data),
    .ll_data_o  (ll_data),
    .uri_data_o (uri_data),
    .lli_data_o (lli_data)
  );

  // LCG multiply registered ahead of the add and mask.
  always_ff @(posedge clk_i) begin
    lcg_prod_q <= seed_q * LcgMul;
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    hash_d       = hash_q;
    nonempty_d   = nonempty_q;
    sel_d        = sel_q;
    cmd_dec_d    = cmd_dec_q;
    seed_d       = seed_q;
    j_d          = j_q;
    vi_d         = vi_q;
    a_d          = a_q;
    b_d          = b_q;
    out_valid_d  = out_valid_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    wr           = '0;
    ur_addr      = a_q;
    ll_addr      = b_q;
    uri_addr     = a_q;
    lli_addr     = b_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        // Identity into all four tables: one entry of one table per cycle, tables in turn.
        wr.wr_en   = 1'b1;
        wr.sel     = cnt_q[1];
        wr.inv     = cnt_q[0];
        wr.wr_addr = vi_q;
        wr.wr_data = vi_q;
        cnt_d = cnt_q + 9'd1;
        if (cnt_q[1:0] == 2'b11) begin
          vi_d  = vi_q + 8'd1;
          cnt_d = '0;
          if (vi_q == 8'hFF) begin
            state_d = StIdle;
          end
        end
      end
      StIdle: begin
        if (accept) begin
          unique case (cmd_e'(command_i))
            CmdKeyChar: begin
              hash_d     = hash_q * HashMul + {16'd0, key_char_i};
              nonempty_d = 1'b1;
            end
            CmdCommit: begin
              sel_d   = key_select_i;
              seed_d  = hash_q[31] ? (32'd0 - hash_q) : hash_q;
              cnt_d   = '0;
              state_d = StFill;
            end
            default: begin
              cmd_dec_d = (command_i == CmdDecrypt);
              if (command_i == CmdDecrypt) begin
                a_d = first_byte_i;
                b_d = b_eff;
              end else begin
                a_d = {first_byte_i[7:4], b_eff[3:0]};
                b_d = {b_eff[7:4], first_byte_i[3:0]};
              end
              state_d = StLook;
            end
          endcase
        end
        // Issue the pair's table reads in the accept cycle.
        ur_addr  = a_d;
        ll_addr  = b_d;
        uri_addr = a_d;
        lli_addr = b_d;
      end
      StLook: begin
        // Wait here while the output register still holds an untaken result.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (cmd_dec_q) begin
            out_first_d  = {p[7:4], q[3:0]};
            out_second_d = {q[7:4], p[3:0]};
          end else begin
            out_first_d  = ur_data;
            out_second_d = ll_data;
          end
          state_d = StIdle;
        end
      end
      StFill: begin
        wr.wr_en   = 1'b1;
        wr.sel     = sel_q;
        wr.wr_addr = cnt_q[7:0];
        wr.wr_data = cnt_q[7:0];
        cnt_d = cnt_q + 9'd1;
        if (cnt_q[7:0] == 8'hFF) begin
          cnt_d   = 9'd255;
          state_d = nonempty_q ? StLcg : StInvRd;
          if (!nonempty_q) cnt_d = '0;
        end
      end
      StLcg: begin
        // Product of the current seed is ready in the following cycle.
        state_d = StMod;
        seed_d  = seed_q;
      end
      StMod: begin
        state_d = StMod;
        if (mod_done) begin
          j_d     = mod_rem;
          state_d = StRdI;
        end
      end
      StRdI: begin
        ur_addr = cnt_q[7:0];
        ll_addr = cnt_q[7:0];
        state_d = StRdJ;
      end
      StRdJ: begin
        vi_d    = rd_fwd;
        ur_addr = j_q;
        ll_addr = j_q;
        state_d = StSwap;
      end
      StSwap: begin
        // Write old entry i at j now; entry j goes to i next cycle via vi.
        wr.wr_en   = 1'b1;
        wr.sel     = sel_q;
        wr.wr_addr = j_q;
        wr.wr_data = vi_q;
        vi_d       = rd_fwd;
        state_d    = StInvWr;
        a_d        = 8'd1;
      end
      StInvRd: begin
        ur_addr = cnt_q[7:0];
        ll_addr = cnt_q[7:0];
        state_d = StInvWr;
        a_d     = 8'd0;
      end
      StInvWr: begin
        if (a_q == 8'd1) begin
          // Second half of a swap; skip if i == j already holds the value.
          wr.wr_en   = (j_q != cnt_q[7:0]);
          wr.sel     = sel_q;
          wr.wr_addr = cnt_q[7:0];
          wr.wr_data = vi_q;
          if (cnt_q == 9'd1) begin
            cnt_d   = '0;
            state_d = StInvRd;
          end else begin
            cnt_d   = cnt_q - 9'd1;
            state_d = StLcg;
          end
        end else begin
          wr.wr_en   = 1'b1;
          wr.sel     = sel_q;
          wr.inv     = 1'b1;
          wr.wr_addr = rd_fwd;
          wr.wr_data = cnt_q[7:0];
          if (cnt_q[7:0] == 8'hFF) begin
            hash_d     = '0;
            nonempty_d = 1'b0;
            state_d    = StIdle;
          end else begin
            cnt_d   = cnt_q + 9'd1;
            state_d = StInvRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // mod_first_q marks entry to StMod, where the seed updates; start_q is registered from it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_first_q <= 1'b0;
    end else begin
      mod_first_q <= (state_q == StLcg);
    end
  end

  assign seed_next = (lcg_prod_q + LcgAdd) & LcgMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      hash_q      <= '0;
      nonempty_q  <= 1'b0;
      vi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hash_q      <= hash_d;
      nonempty_q  <= nonempty_d;
      vi_q        <= vi_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Divider start register; the divider starts in the cycle after the seed update, from the new seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= mod_first_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mod_first_q) begin
      seed_q <= seed_next;
    end else begin
      seed_q <= seed_d;
    end
    sel_q        <= sel_d;
    cmd_dec_q    <= cmd_dec_d;
    j_q          <= j_d;
    a_q          <= a_d;
    b_q          <= b_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;

  // A result is only produced from a lookup.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == StLook)
    else $error("result without lookup");

  // No input is taken outside StIdle, so none during a clear, a lookup or a commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o)
    else $error("input accepted while busy");

  // A pending result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_first_o))
    else $error("result dropped");

endmodule

// File: verif/tb_byte_four_square_cipher_top.sv
// Self-checking testbench for byte_four_square_cipher_top.
// It predicts every pair result from its own copy of the keyed squares and checks the outputs.
// Depends on bfsc_pkg and the cipher RTL.
`timescale 1ns / 1ps

module tb_byte_four_square_cipher_top;
  import bfsc_pkg::*;

  localparam int unsigned MaxCycles = 4_000_000;
  localparam int unsigned NumPairs  = 500;

  typedef struct {
    cmd_e        cmd;
    logic        sel;
    logic [15:0] ch;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        b_ok;
    bit          drain;   // hold this item until every pending pair result is back
  } cipher_item_t;

  typedef struct {
    logic [7:0] first;
    logic [7:0] second;
  } pair_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = CmdKeyChar;
  logic        key_select_i = 1'b0;
  logic [15:0] key_char_i = '0;
  logic [7:0]  first_byte_i = '0;
  logic [7:0]  second_byte_i = '0;
  logic        second_valid_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_first_o;
  logic [7:0]  out_second_o;

  byte_four_square_cipher_top u_top (.*);

  cipher_item_t pending_items[$];
  pair_result_t expected_pairs[$];
  cipher_item_t drv_item;
  int unsigned  sent_cnt = 0;
  int unsigned  recv_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  err_cnt = 0;

  // Predictor state: keyed squares, their inverses and the keyword hash.
  logic [7:0]  ur_tab[256];
  logic [7:0]  ll_tab[256];
  logic [7:0]  ur_inv[256];
  logic [7:0]  ll_inv[256];
  logic [31:0] kw_hash;
  bit          kw_nonempty;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Rebuild one keyed square from the pending keyword and return it with its inverse.
  task automatic shuffle_square(output logic [7:0] tab[256], output logic [7:0] inv[256]);
    logic [31:0] seed;
    logic [31:0] j;
    logic [7:0]  tmp;
    for (int k = 0; k < 256; k++) tab[k] = k[7:0];
    if (kw_nonempty) begin
      seed = kw_hash[31] ? (32'd0 - kw_hash) : kw_hash;
      for (int i = 255; i > 0; i--) begin
        seed = (seed * LcgMul + LcgAdd) & LcgMask;
        j = seed % 32'(i + 1);
        tmp = tab[i];
        tab[i] = tab[j[7:0]];
        tab[j[7:0]] = tmp;
      end
    end
    for (int k = 0; k < 256; k++) inv[tab[k]] = k[7:0];
  endtask

  // Apply one accepted item to the predictor; pairs queue an expected result.
  task automatic predict_cipher(input cipher_item_t it);
    logic [7:0]   b;
    logic [7:0]   p;
    logic [7:0]   q;
    pair_result_t r;
    b = it.b_ok ? it.b : PadByte;
    case (it.cmd)
      CmdKeyChar: begin
        kw_hash = kw_hash * HashMul + {16'd0, it.ch};
        kw_nonempty = 1'b1;
      end
      CmdCommit: begin
        if (it.sel) shuffle_square(ll_tab, ll_inv);
        else shuffle_square(ur_tab, ur_inv);
        kw_hash = '0;
        kw_nonempty = 1'b0;
      end
      CmdEncrypt: begin
        r.first  = ur_tab[{it.a[7:4], b[3:0]}];
        r.second = ll_tab[{b[7:4], it.a[3:0]}];
        expected_pairs.push_back(r);
      end
      default: begin
        p = ur_inv[it.a];
        q = ll_inv[b];
        r.first  = {p[7:4], q[3:0]};
        r.second = {q[7:4], p[3:0]};
        expected_pairs.push_back(r);
      end
    endcase
  endtask

  function automatic cipher_item_t make_item(cmd_e cmd, logic [15:0] ch, logic [7:0] a,
                                             logic [7:0] b, logic b_ok);
    cipher_item_t it;
    it.cmd = cmd;
    it.sel = 1'($urandom_range(1));
    it.ch = ch;
    it.a = a;
    it.b = b;
    it.b_ok = b_ok;
    it.drain = 1'b0;
    return it;
  endfunction

  function automatic cipher_item_t rand_item(cmd_e cmd);
    return make_item(cmd, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), $urandom_range(7) != 0);
  endfunction

  function automatic cipher_item_t commit_item(logic sel);
    cipher_item_t it;
    it = rand_item(CmdCommit);
    it.sel = sel;
    return it;
  endfunction

  // Stimulus: directed corners first, then keyword commits mixed into random pairs.
  initial begin
    longint unsigned rest;
    int unsigned     digits[$];
    int unsigned     pairs;
    cipher_item_t    it;

    for (int k = 0; k < 256; k++) begin
      ur_tab[k] = k[7:0];
      ll_tab[k] = k[7:0];
      ur_inv[k] = k[7:0];
      ll_inv[k] = k[7:0];
    end
    kw_hash = '0;
    kw_nonempty = 1'b0;

    // Identity squares: extreme bytes and the odd tail.
    pending_items.push_back(make_item(CmdEncrypt, 16'h0000, 8'h00, 8'h00, 1'b1));
    pending_items.push_back(make_item(CmdEncrypt, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
    pending_items.push_back(make_item(CmdDecrypt, 16'h0000, 8'hA5, 8'h5A, 1'b0));
    // Keyword with extreme characters into the upper right square.
    pending_items.push_back(make_item(CmdKeyChar, 16'hFFFF, 8'h00, 8'h00, 1'b1));
    pending_items.push_back(make_item(CmdKeyChar, 16'h0000, 8'hFF, 8'hFF, 1'b0));
    pending_items.push_back(commit_item(1'b0));
    pending_items.push_back(make_item(CmdEncrypt, 16'h0000, 8'h0F, 8'hF0, 1'b1));
    pending_items.push_back(make_item(CmdDecrypt, 16'h0000, 8'hFF, 8'h00, 1'b1));
    // Most negative hash: the digits of 2^31 in base 31 rebuild it exactly.
    rest = 64'd2147483648;
    while (rest != 0) begin
      digits.push_front(32'(rest % 31));
      rest = rest / 31;
    end
    foreach (digits[k]) begin
      pending_items.push_back(make_item(CmdKeyChar, 16'(digits[k]), 8'h00, 8'h00, 1'b1));
    end
    pending_items.push_back(commit_item(1'b1));
    pending_items.push_back(make_item(CmdEncrypt, 16'h0000, 8'h3C, 8'hC3, 1'b0));
    // Zero hash from a nonempty keyword still shuffles.
    pending_items.push_back(make_item(CmdKeyChar, 16'h0000, 8'h00, 8'h00, 1'b1));
    pending_items.push_back(commit_item(1'b0));
    pending_items.push_back(make_item(CmdDecrypt, 16'h0000, 8'h12, 8'h34, 1'b1));
    // Commit with no characters returns the square to the identity.
    pending_items.push_back(commit_item(1'b1));
    it = make_item(CmdEncrypt, 16'h0000, 8'h80, 8'h7F, 1'b1);
    it.drain = 1'b1;
    pending_items.push_back(it);

    pairs = 0;
    while (pairs < NumPairs) begin
      if ($urandom_range(39) == 0) begin
        repeat ($urandom_range(1, 8)) pending_items.push_back(rand_item(CmdKeyChar));
        pending_items.push_back(rand_item(CmdCommit));
      end else if ($urandom_range(49) == 0) begin
        pending_items.push_back(rand_item(CmdKeyChar));
      end else begin
        it = rand_item($urandom_range(1) ? CmdEncrypt : CmdDecrypt);
        it.drain = (pairs == NumPairs / 2);
        pending_items.push_back(it);
        pairs++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: presents queued items, idling at random outside a quiet window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_cipher(drv_item);
        sent_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 &&
            (($urandom_range(99) >= 16) || (sent_cnt >= 250 && sent_cnt < 400)) &&
            !(pending_items[0].drain && expected_pairs.size() > 0)) begin
          drv_item = pending_items.pop_front();
          command_i <= drv_item.cmd;
          key_select_i <= drv_item.sel;
          key_char_i <= drv_item.ch;
          first_byte_i <= drv_item.a;
          second_byte_i <= drv_item.b;
          second_valid_i <= drv_item.b_ok;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and a field-by-field check of each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    pair_result_t r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        recv_cnt++;
        if (expected_pairs.size() == 0) begin
          $error("unexpected result: out_first %0h out_second %0h", out_first_o, out_second_o);
          err_cnt++;
        end else begin
          r = expected_pairs.pop_front();
          if (out_first_o !== r.first) begin
            $error("out_first: expected %0h actual %0h", r.first, out_first_o);
            err_cnt++;
          end
          if (out_second_o !== r.second) begin
            $error("out_second: expected %0h actual %0h", r.second, out_second_o);
            err_cnt++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= 16) || (recv_cnt >= 100 && recv_cnt < 200);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // End of run: everything sent and answered, then a short quiet tail.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_pairs.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && expected_pairs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bfsc_pkg.sv
hw/rtl/bfsc_mod.sv
hw/rtl/bfsc_store.sv
hw/rtl/byte_four_square_cipher_top.sv
verif/tb_byte_four_square_cipher_top.sv
